// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/crtm_pkg.sv =====
`timescale 1ns / 1ps

package crtm_pkg;

	localparam int unsigned TableEntriesDefault = 32;
	localparam int unsigned CompareBytesDefault = 5;
	localparam int unsigned BoundBytes          = 5;
	localparam int unsigned MaxDigits           = 20;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // input transfer: capture item, write entry on a write
		logic scan;    // scan in progress: issue reads, capture first hit
		logic finish;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;     // entry under compare matches
		logic last;    // entry under compare is the final one
	} status_t;

endpackage

// ===== rtl/core/crtm_datapath.sv =====
`timescale 1ns / 1ps

module crtm_datapath #(
	parameter int unsigned TABLE_ENTRIES = crtm_pkg::TableEntriesDefault,
	parameter int unsigned COMPARE_BYTES = crtm_pkg::CompareBytesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crtm_pkg::cmd_t    cmd,
	output crtm_pkg::status_t st,
	input  logic              op,
	input  logic [39:0]       card_digits_first,
	input  logic [39:0]       card_digits_last,
	input  logic [4:0]        entry_slot,
	input  logic [39:0]       range_low,
	input  logic [39:0]       range_high,
	input  logic [4:0]        needed_length,
	input  logic [7:0]        range_tag,
	output logic              matched,
	output logic [4:0]        hit_slot,
	output logic [7:0]        hit_tag,
	output logic [4:0]        card_length
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned CMP_BYTES =
		(COMPARE_BYTES < crtm_pkg::BoundBytes) ? COMPARE_BYTES : crtm_pkg::BoundBytes;
	localparam int unsigned CMP_W = 8 * CMP_BYTES;
	localparam int unsigned SLOT_W = IDX_W + 5;
	localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0]  CNT_END    = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_ENTRIES - 1);

	// digits up to the first filler nibble
	function automatic logic [4:0] count_digits(input logic [79:0] num);
		logic [4:0] n;
		n = 5'(crtm_pkg::MaxDigits);
		for (int k = crtm_pkg::MaxDigits - 1; k >= 0; k--) begin
			if (num[79 - 4*k -: 4] == 4'hF) begin
				n = 5'(k);
			end
		end
		return n;
	endfunction

	logic [CMP_W-1:0] mem_low  [TABLE_ENTRIES];
	logic [CMP_W-1:0] mem_high [TABLE_ENTRIES];
	logic [4:0]       mem_rule [TABLE_ENTRIES];
	logic [7:0]       mem_tag  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic [CMP_W-1:0] key_q;
	logic [4:0]       len_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CMP_W-1:0] low_s1, high_s1;
	logic [4:0]       rule_s1;
	logic [7:0]       tag_s1;
	logic             ent_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             busy_s1;

	logic             res_matched_q;
	logic [4:0]       res_slot_q;
	logic [7:0]       res_tag_q;

	logic             out_matched_q;
	logic [4:0]       out_slot_q;
	logic [7:0]       out_tag_q;
	logic [4:0]       out_len_q;

	logic [SLOT_W-1:0] slot_ext;
	logic [IDX_W-1:0]  wr_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              issue;
	logic [IDX_W+4:0]  idx_ext;
	logic [CMP_W-1:0]  eff_low, eff_high;
	logic [4:0]        eff_rule;
	logic [7:0]        eff_tag;
	logic              match;

	assign slot_ext = {{IDX_W{1'b0}}, entry_slot};
	assign wr_addr  = slot_ext[IDX_W-1:0];
	assign wr_en    = cmd.load && (op == crtm_pkg::OP_WRITE) && (slot_ext < SLOT_LIMIT);
	assign rd_addr  = cnt_q[IDX_W-1:0];
	assign issue    = cmd.scan && (cnt_q != CNT_END);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_low[wr_addr]  <= range_low[39 -: CMP_W];
			mem_high[wr_addr] <= range_high[39 -: CMP_W];
			mem_rule[wr_addr] <= needed_length;
			mem_tag[wr_addr]  <= range_tag;
		end
		if (issue) begin
			low_s1  <= mem_low[rd_addr];
			high_s1 <= mem_high[rd_addr];
			rule_s1 <= mem_rule[rd_addr];
			tag_s1  <= mem_tag[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			busy_s1 <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ent_vld_s1 <= vld_q[rd_addr];
			idx_s1     <= rd_addr;
		end
		if (cmd.load) begin
			key_q <= card_digits_first[39 -: CMP_W];
			len_q <= (op == crtm_pkg::OP_LOOKUP) ?
				count_digits({card_digits_first, card_digits_last}) : 5'd0;
		end
	end

	// never-written entries read as zero
	assign eff_low  = ent_vld_s1 ? low_s1  : '0;
	assign eff_high = ent_vld_s1 ? high_s1 : '0;
	assign eff_rule = ent_vld_s1 ? rule_s1 : '0;
	assign eff_tag  = ent_vld_s1 ? tag_s1  : '0;

	// leading bytes MSB first compare as one unsigned number
	assign match = ((eff_rule == 5'd0) || (eff_rule == len_q)) &&
		(key_q >= eff_low) && (key_q <= eff_high);

	assign st.hit  = busy_s1 && match;
	assign st.last = busy_s1 && (idx_s1 == IDX_LAST);

	assign idx_ext = {5'd0, idx_s1};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_matched_q <= 1'b0;
			res_slot_q    <= '0;
			res_tag_q     <= '0;
		end else if (cmd.scan && st.hit) begin
			res_matched_q <= 1'b1;
			res_slot_q    <= idx_ext[4:0];
			res_tag_q     <= eff_tag;
		end
		if (cmd.finish) begin
			out_matched_q <= res_matched_q;
			out_slot_q    <= res_slot_q;
			out_tag_q     <= res_tag_q;
			out_len_q     <= len_q;
		end
	end

	assign matched     = out_matched_q;
	assign hit_slot    = out_slot_q;
	assign hit_tag     = out_tag_q;
	assign card_length = out_len_q;

endmodule

// ===== rtl/core/crtm_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crtm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	output logic              out_valid,
	input  logic              out_ready,
	output crtm_pkg::cmd_t    cmd,
	input  crtm_pkg::status_t st
);

	crtm_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crtm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			crtm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (op == crtm_pkg::OP_LOOKUP) ?
						crtm_pkg::ST_SCAN : crtm_pkg::ST_FINISH;
				end
			end
			crtm_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.hit || st.last) begin
					state_d = crtm_pkg::ST_FINISH;
				end
			end
			crtm_pkg::ST_FINISH: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = crtm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crtm_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_finish_room, cmd.finish |-> (!out_valid_q || out_ready), "result overwrites pending transfer")
	`ASSERT_CLK(a_scan_ends, (state_q == crtm_pkg::ST_SCAN && (st.hit || st.last)) |=> (state_q == crtm_pkg::ST_FINISH), "scan did not stop at hit or end")
	`ASSERT_CLK(a_accept_busy, (in_valid && in_ready) |=> !in_ready, "second item taken before result")

endmodule

// ===== rtl/core/card_range_table_match_unit.sv =====
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready   | op, card_digits_first/last, entry_slot, range_low/high,
//         |                       | needed_length, range_tag
// out     | out_valid / out_ready | matched, hit_slot, hit_tag, card_length
//
// Write: the input transfer moves the controller from ST_IDLE to ST_FINISH, which loads
// the output register once it is free. Lookup: one-entry-per-cycle scan over the table
// memory read port, then ST_FINISH; a hit ends the scan early.
// One item at a time; a result may wait in the output register while the next item
// is taken. Reset clears the table valid bits at once, no clearing pass.

module card_range_table_match_unit #(
	parameter int unsigned TABLE_ENTRIES = crtm_pkg::TableEntriesDefault,
	parameter int unsigned COMPARE_BYTES = crtm_pkg::CompareBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [39:0] card_digits_first,
	input  logic [39:0] card_digits_last,
	input  logic [4:0]  entry_slot,
	input  logic [39:0] range_low,
	input  logic [39:0] range_high,
	input  logic [4:0]  needed_length,
	input  logic [7:0]  range_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic [4:0]  hit_slot,
	output logic [7:0]  hit_tag,
	output logic [4:0]  card_length
);

	crtm_pkg::cmd_t    cmd;
	crtm_pkg::status_t st;

	crtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	crtm_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COMPARE_BYTES (COMPARE_BYTES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.op                (op),
		.card_digits_first (card_digits_first),
		.card_digits_last  (card_digits_last),
		.entry_slot        (entry_slot),
		.range_low         (range_low),
		.range_high        (range_high),
		.needed_length     (needed_length),
		.range_tag         (range_tag),
		.matched           (matched),
		.hit_slot          (hit_slot),
		.hit_tag           (hit_tag),
		.card_length       (card_length)
	);

endmodule
